FILE: rtl/lst_pkg.sv
// Shared types and constants for the latency statistics table.
// Used by lst_ctrl, lst_dpath and latency_stats_table_top; no dependencies.
`default_nettype none

package lst_pkg;

  localparam int NSEG    = 5;
  localparam int VAL_W   = 64;
  localparam int TIME_W  = 48;
  localparam int STAMP_W = 40;
  localparam int TYPE_W  = 6;
  localparam int SEL_W   = 3;
  localparam int BCNT_W  = 32;

  localparam logic [VAL_W-1:0] ALL_ONES = '1;

  // Segment positions inside an entry.
  localparam int SEG_OVH   = 0;
  localparam int SEG_FS    = 1;
  localparam int SEG_QUEUE = 2;
  localparam int SEG_NET   = 3;
  localparam int SEG_TOTAL = 4;

  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [1:0] {
    OP_CLIENT = 2'd0,
    OP_SERVER = 2'd1,
    OP_RESET  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    val_t sum;
    val_t lo;
    val_t hi;
  } seg_t;

  typedef struct packed {
    val_t                 count;
    logic [STAMP_W-1:0]   stamp;
    seg_t [NSEG-1:0]      seg;
  } row_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_VALS,
    ST_ACC,
    ST_CHK,
    ST_RD,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic in_load;
    logic prep_load;
    logic vals_load;
    logic acc;
    logic batch_clear;
    logic clr_write;
    logic mem_rd;
    logic upd_write;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic last;
    logic type_ok;
    logic batch_apply;
    logic clr_done;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/latency_stats_table_top.sv
// Latency statistics table, top level. Items are handled one at a time from IDLE: a client
// record passes PREP, VALS and ACC, then CHK when it ends a batch, then RD and UPD when that
// batch is applied; a server record passes PREP, VALS, then RD and UPD for a type in range;
// a read passes RD and OUT to a result in the output register; a table reset sweeps its
// NUM_TYPES rows. After rst (synchronous, active high) a sweep of 2*NUM_TYPES rows clears
// both tables before the first item is taken. Depends on lst_pkg, lst_ctrl, lst_dpath.
`default_nettype none

module latency_stats_table_top #(
  parameter int NUM_TYPES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   op,
  input  wire logic                         side,
  input  wire logic                         record_valid,
  input  wire logic [lst_pkg::TYPE_W-1:0]   req_kind,
  input  wire logic                         batch_last,
  input  wire logic [lst_pkg::TIME_W-1:0]   req_net_time,
  input  wire logic [lst_pkg::TIME_W-1:0]   reply_net_time,
  input  wire logic [lst_pkg::TIME_W-1:0]   queue_time,
  input  wire logic [lst_pkg::TIME_W-1:0]   process_time,
  input  wire logic [lst_pkg::TIME_W-1:0]   fs_time,
  input  wire logic [lst_pkg::SEL_W-1:0]    segment_sel,
  input  wire logic [lst_pkg::STAMP_W-1:0]  now_seconds,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [lst_pkg::VAL_W-1:0]         entry_count,
  output logic [lst_pkg::VAL_W-1:0]         seg_sum,
  output logic [lst_pkg::VAL_W-1:0]         seg_min,
  output logic [lst_pkg::VAL_W-1:0]         seg_max,
  output logic [lst_pkg::STAMP_W-1:0]       reset_stamp
);

  // The client table occupies entry rows 0 to NUM_TYPES-1 and the server table
  // the rows above it. Each row carries the count, the reset stamp and the sum,
  // minimum and maximum of all five segments, so an update is one row read and
  // one row write. Client records gather in a batch accumulator and reach the
  // table only when the batch closes. Only reads produce a result item; it sits
  // in the output register while the block already takes the next item.

  lst_pkg::cmd_t    cmd;
  lst_pkg::status_t status;

  lst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lst_dpath #(
    .NUM_TYPES (NUM_TYPES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .op             (op),
    .side           (side),
    .record_valid   (record_valid),
    .req_kind       (req_kind),
    .batch_last     (batch_last),
    .req_net_time   (req_net_time),
    .reply_net_time (reply_net_time),
    .queue_time     (queue_time),
    .process_time   (process_time),
    .fs_time        (fs_time),
    .segment_sel    (segment_sel),
    .now_seconds    (now_seconds),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .entry_count    (entry_count),
    .seg_sum        (seg_sum),
    .seg_min        (seg_min),
    .seg_max        (seg_max),
    .reset_stamp    (reset_stamp)
  );

endmodule

`default_nettype wire

FILE: rtl/lst_ctrl.sv
// Sequencer for the latency statistics table.
// Depends on lst_pkg; drives lst_dpath through cmd_t and reads status_t.
`default_nettype none

module lst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [1:0]        op,
  output logic                   in_ready,
  input  wire lst_pkg::status_t  status,
  output lst_pkg::cmd_t          cmd
);

  lst_pkg::state_t state;
  lst_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lst_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      lst_pkg::ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (status.clr_done) begin
          state_next = lst_pkg::ST_IDLE;
        end
      end
      lst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          case (lst_pkg::op_t'(op))
            lst_pkg::OP_CLIENT: state_next = lst_pkg::ST_PREP;
            lst_pkg::OP_SERVER: state_next = lst_pkg::ST_PREP;
            lst_pkg::OP_RESET:  state_next = lst_pkg::ST_CLEAR;
            lst_pkg::OP_READ:   state_next = lst_pkg::ST_RD;
            default:            state_next = lst_pkg::ST_IDLE;
          endcase
        end
      end
      lst_pkg::ST_PREP: begin
        cmd.prep_load = 1'b1;
        state_next    = lst_pkg::ST_VALS;
      end
      lst_pkg::ST_VALS: begin
        cmd.vals_load = 1'b1;
        if (status.op == lst_pkg::OP_CLIENT) begin
          state_next = lst_pkg::ST_ACC;
        end else if (status.type_ok) begin
          state_next = lst_pkg::ST_RD;
        end else begin
          state_next = lst_pkg::ST_IDLE;
        end
      end
      lst_pkg::ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.last ? lst_pkg::ST_CHK : lst_pkg::ST_IDLE;
      end
      lst_pkg::ST_CHK: begin
        if (status.batch_apply) begin
          state_next = lst_pkg::ST_RD;
        end else begin
          cmd.batch_clear = 1'b1;
          state_next      = lst_pkg::ST_IDLE;
        end
      end
      lst_pkg::ST_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = (status.op == lst_pkg::OP_READ) ? lst_pkg::ST_OUT : lst_pkg::ST_UPD;
      end
      lst_pkg::ST_UPD: begin
        cmd.upd_write   = 1'b1;
        cmd.batch_clear = (status.op == lst_pkg::OP_CLIENT);
        state_next      = lst_pkg::ST_IDLE;
      end
      lst_pkg::ST_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = lst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lst_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Every entry update is a read-modify-write: the read went out in the cycle before.
  a_upd_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_write |-> $past(cmd.mem_rd))
    else $error("entry write without preceding read");

  // A result never overwrites one that is still waiting downstream.
  a_no_out_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !status.out_busy)
    else $error("output register overrun");

  // Leaving reset always starts the table clearing sweep.
  a_reset_sweep: assert property (@(posedge clk)
    $fell(rst) |-> state == lst_pkg::ST_CLEAR)
    else $error("no clearing sweep after reset");

  // No item is taken while the sweep or an entry write is in progress.
  a_no_accept_on_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.clr_write || cmd.upd_write) |-> !in_ready)
    else $error("item accepted during table write");
`endif

endmodule

`default_nettype wire

FILE: rtl/lst_dpath.sv
// Datapath for the latency statistics table: input registers, segment values,
// client batch accumulator, entry memory and output register. Depends on lst_pkg.
`default_nettype none

module lst_dpath #(
  parameter int NUM_TYPES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lst_pkg::cmd_t                cmd,
  output lst_pkg::status_t                  status,
  input  wire logic [1:0]                   op,
  input  wire logic                         side,
  input  wire logic                         record_valid,
  input  wire logic [lst_pkg::TYPE_W-1:0]   req_kind,
  input  wire logic                         batch_last,
  input  wire logic [lst_pkg::TIME_W-1:0]   req_net_time,
  input  wire logic [lst_pkg::TIME_W-1:0]   reply_net_time,
  input  wire logic [lst_pkg::TIME_W-1:0]   queue_time,
  input  wire logic [lst_pkg::TIME_W-1:0]   process_time,
  input  wire logic [lst_pkg::TIME_W-1:0]   fs_time,
  input  wire logic [lst_pkg::SEL_W-1:0]    segment_sel,
  input  wire logic [lst_pkg::STAMP_W-1:0]  now_seconds,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [lst_pkg::VAL_W-1:0]         entry_count,
  output logic [lst_pkg::VAL_W-1:0]         seg_sum,
  output logic [lst_pkg::VAL_W-1:0]         seg_min,
  output logic [lst_pkg::VAL_W-1:0]         seg_max,
  output logic [lst_pkg::STAMP_W-1:0]       reset_stamp
);

  localparam int DEPTH = 2 * NUM_TYPES;
  localparam int AW    = $clog2(DEPTH);

  // Latched input item.
  lst_pkg::op_t                 op_q;
  logic                         side_q;
  logic                         valid_q;
  logic [lst_pkg::TYPE_W-1:0]   type_q;
  logic                         last_q;
  logic [lst_pkg::TIME_W-1:0]   rqn_q;
  logic [lst_pkg::TIME_W-1:0]   rpn_q;
  logic [lst_pkg::TIME_W-1:0]   qt_q;
  logic [lst_pkg::TIME_W-1:0]   pt_q;
  logic [lst_pkg::TIME_W-1:0]   ft_q;
  logic [lst_pkg::SEL_W-1:0]    sel_q;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_q    <= lst_pkg::op_t'(op);
      side_q  <= side;
      valid_q <= record_valid;
      type_q  <= req_kind;
      last_q  <= batch_last;
      rqn_q   <= req_net_time;
      rpn_q   <= reply_net_time;
      qt_q    <= queue_time;
      pt_q    <= process_time;
      ft_q    <= fs_time;
      sel_q   <= segment_sel;
    end
  end

  // First arithmetic stage: one add or subtract per value.
  lst_pkg::val_t ovh;
  lst_pkg::val_t qp;
  lst_pkg::val_t diff;
  logic          both;

  always_ff @(posedge clk) begin
    if (cmd.prep_load) begin
      ovh  <= lst_pkg::VAL_W'(pt_q) - lst_pkg::VAL_W'(ft_q);
      qp   <= lst_pkg::VAL_W'(qt_q) + lst_pkg::VAL_W'(pt_q);
      diff <= lst_pkg::VAL_W'(rpn_q) - lst_pkg::VAL_W'(rqn_q);
      both <= (rqn_q != '0) && (rpn_q != '0);
    end
  end

  // Second stage: the five segment values of the record.
  lst_pkg::val_t v [lst_pkg::NSEG];

  always_ff @(posedge clk) begin
    if (cmd.vals_load) begin
      v[lst_pkg::SEG_OVH]   <= ovh;
      v[lst_pkg::SEG_FS]    <= lst_pkg::VAL_W'(ft_q);
      v[lst_pkg::SEG_QUEUE] <= lst_pkg::VAL_W'(qt_q);
      if (op_q == lst_pkg::OP_CLIENT) begin
        v[lst_pkg::SEG_NET]   <= both ? (diff - qp) : '0;
        v[lst_pkg::SEG_TOTAL] <= both ? diff : '0;
      end else begin
        v[lst_pkg::SEG_NET]   <= '0;
        v[lst_pkg::SEG_TOTAL] <= qp;
      end
    end
  end

  // Client batch accumulator.
  lst_pkg::val_t                batch_sums [lst_pkg::NSEG];
  logic [lst_pkg::BCNT_W-1:0]   batch_count;
  logic                         batch_known;
  logic [lst_pkg::TYPE_W-1:0]   batch_type;

  always_ff @(posedge clk) begin
    if (rst || cmd.batch_clear) begin
      for (int s = 0; s < lst_pkg::NSEG; s++) begin
        batch_sums[s] <= '0;
      end
      batch_count <= '0;
      batch_known <= 1'b0;
      batch_type  <= '0;
    end else if (cmd.acc && valid_q) begin
      for (int s = 0; s < lst_pkg::NSEG; s++) begin
        batch_sums[s] <= batch_sums[s] + v[s];
      end
      batch_count <= batch_count + 1'b1;
      if (!batch_known) begin
        batch_known <= 1'b1;
        batch_type  <= type_q;
      end
    end
  end

  logic type_ok;
  logic batch_ok;

  assign type_ok  = 32'(type_q) < 32'(NUM_TYPES);
  assign batch_ok = 32'(batch_type) < 32'(NUM_TYPES);

  // Table clearing sweep.
  logic [AW-1:0]                clr_addr;
  logic [AW-1:0]                clr_end;
  logic [lst_pkg::STAMP_W-1:0]  clr_stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      clr_end   <= AW'(DEPTH - 1);
      clr_stamp <= '0;
    end else if (cmd.in_load && (lst_pkg::op_t'(op) == lst_pkg::OP_RESET)) begin
      clr_addr  <= side ? AW'(NUM_TYPES) : '0;
      clr_end   <= side ? AW'(DEPTH - 1) : AW'(NUM_TYPES - 1);
      clr_stamp <= now_seconds;
    end else if (cmd.clr_write) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Entry memory: one row per table entry.
  lst_pkg::row_t  mem [DEPTH];
  lst_pkg::row_t  rdata;
  lst_pkg::row_t  clr_row;
  lst_pkg::row_t  upd_row;
  lst_pkg::row_t  wdata;
  logic [AW-1:0]  mem_addr;
  logic           mem_we;
  logic           mem_re;
  lst_pkg::val_t  add_cnt;
  lst_pkg::val_t  nv;

  always_comb begin
    if (cmd.clr_write) begin
      mem_addr = clr_addr;
    end else if (op_q == lst_pkg::OP_CLIENT) begin
      mem_addr = AW'(batch_type);
    end else if (op_q == lst_pkg::OP_SERVER) begin
      mem_addr = AW'(NUM_TYPES) + AW'(type_q);
    end else begin
      mem_addr = (side_q ? AW'(NUM_TYPES) : AW'(0)) + AW'(type_q);
    end
  end

  always_comb begin
    clr_row.count = '0;
    clr_row.stamp = clr_stamp;
    for (int s = 0; s < lst_pkg::NSEG; s++) begin
      clr_row.seg[s].sum = '0;
      clr_row.seg[s].lo  = lst_pkg::ALL_ONES;
      clr_row.seg[s].hi  = '0;
    end
  end

  // Fold the new values into the entry: every segment lane is independent.
  always_comb begin
    nv            = '0;
    add_cnt       = (op_q == lst_pkg::OP_CLIENT) ? lst_pkg::VAL_W'(batch_count)
                                                 : lst_pkg::VAL_W'(1);
    upd_row.count = rdata.count + add_cnt;
    upd_row.stamp = rdata.stamp;
    for (int s = 0; s < lst_pkg::NSEG; s++) begin
      nv = (op_q == lst_pkg::OP_CLIENT) ? batch_sums[s] : v[s];
      upd_row.seg[s].sum = rdata.seg[s].sum + nv;
      upd_row.seg[s].lo  = (nv < rdata.seg[s].lo) ? nv : rdata.seg[s].lo;
      upd_row.seg[s].hi  = (nv > rdata.seg[s].hi) ? nv : rdata.seg[s].hi;
    end
  end

  assign mem_we = cmd.clr_write || cmd.upd_write;
  assign wdata  = cmd.clr_write ? clr_row : upd_row;
  assign mem_re = cmd.mem_rd && ((op_q != lst_pkg::OP_READ) || type_ok);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  // Output register.
  logic sel_ok;

  assign sel_ok = sel_q < lst_pkg::SEL_W'(lst_pkg::NSEG);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      entry_count <= type_ok ? rdata.count : '0;
      reset_stamp <= type_ok ? rdata.stamp : '0;
      if (type_ok && sel_ok) begin
        seg_sum <= rdata.seg[sel_q].sum;
        seg_min <= rdata.seg[sel_q].lo;
        seg_max <= rdata.seg[sel_q].hi;
      end else begin
        seg_sum <= '0;
        seg_min <= lst_pkg::ALL_ONES;
        seg_max <= '0;
      end
    end
  end

  assign status.op          = op_q;
  assign status.last        = last_q;
  assign status.type_ok     = type_ok;
  assign status.batch_apply = (batch_count != '0) && batch_ok;
  assign status.clr_done    = (clr_addr == clr_end);
  assign status.out_busy    = out_valid && !out_ready;

endmodule

`default_nettype wire

FILE: test/latency_stats_table_top_test.sv
// Self-checking testbench for latency_stats_table_top: directed rows, then random phases.
// Expected read answers come from a behavioral copy of both tables inside this file.
// Depends on lst_pkg and the RTL of latency_stats_table_top only.
`default_nettype none

module latency_stats_table_top_test;

  // The block is built for 64 request types, so a 6-bit type always lands on an entry.
  localparam int NTYPES      = 64;
  localparam int NDIR        = 26;
  // Random items per idling phase; four phases bring the run to about 700 items.
  localparam int PHASE_ITEMS = 170;
  // Generous bound: the clearing sweep plus every item at its worst many times over.
  localparam int CYCLE_LIMIT = 400000;
  // A table reset sweeps NTYPES rows and sends nothing back, so the tail covers it.
  localparam int TAIL_CYCLES = 3 * NTYPES;
  localparam int MAX_REPORTS = 40;

  // Segment selects past the last segment read count and stamp with an empty segment.
  localparam int SEG_BEYOND = lst_pkg::NSEG;
  localparam int SEG_TOP    = 7;

  localparam logic [lst_pkg::TIME_W-1:0]  TIME_MAX  = '1;
  localparam logic [lst_pkg::STAMP_W-1:0] STAMP_MAX = '1;

  // One input item, one field per port.
  typedef struct packed {
    lst_pkg::op_t                op;
    logic                        side;
    logic                        rec_ok;
    logic [lst_pkg::TYPE_W-1:0]  rtype;
    logic                        batch_end;
    logic [lst_pkg::TIME_W-1:0]  req_t;
    logic [lst_pkg::TIME_W-1:0]  rep_t;
    logic [lst_pkg::TIME_W-1:0]  q_t;
    logic [lst_pkg::TIME_W-1:0]  p_t;
    logic [lst_pkg::TIME_W-1:0]  f_t;
    logic [lst_pkg::SEL_W-1:0]   sel;
    logic [lst_pkg::STAMP_W-1:0] now;
  } stim_t;

  // One read answer.
  typedef struct packed {
    lst_pkg::val_t               count;
    lst_pkg::val_t               sum;
    lst_pkg::val_t               lo;
    lst_pkg::val_t               hi;
    logic [lst_pkg::STAMP_W-1:0] stamp;
  } readout_t;

  // A directed row either carries a typed-in answer (pinned) or leaves it to the tables below.
  typedef struct packed {
    stim_t    stim;
    logic     pinned;
    readout_t want;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   op;
  logic                         side;
  logic                         record_valid;
  logic [lst_pkg::TYPE_W-1:0]   req_kind;
  logic                         batch_last;
  logic [lst_pkg::TIME_W-1:0]   req_net_time;
  logic [lst_pkg::TIME_W-1:0]   reply_net_time;
  logic [lst_pkg::TIME_W-1:0]   queue_time;
  logic [lst_pkg::TIME_W-1:0]   process_time;
  logic [lst_pkg::TIME_W-1:0]   fs_time;
  logic [lst_pkg::SEL_W-1:0]    segment_sel;
  logic [lst_pkg::STAMP_W-1:0]  now_seconds;
  logic                         out_valid;
  logic                         out_ready;
  logic [lst_pkg::VAL_W-1:0]    entry_count;
  logic [lst_pkg::VAL_W-1:0]    seg_sum;
  logic [lst_pkg::VAL_W-1:0]    seg_min;
  logic [lst_pkg::VAL_W-1:0]    seg_max;
  logic [lst_pkg::STAMP_W-1:0]  reset_stamp;

  // Idling knobs, changed between phases. Percentages of cycles spent idle or stalled.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int mismatch_count = 0;
  int cycle_count    = 0;

  // Behavioral copy of both tables: [side][type] and [side][type][segment].
  lst_pkg::val_t               tally     [2][NTYPES];
  logic [lst_pkg::STAMP_W-1:0] stamp_of  [2][NTYPES];
  lst_pkg::val_t               seg_total [2][NTYPES][lst_pkg::NSEG];
  lst_pkg::val_t               seg_low   [2][NTYPES][lst_pkg::NSEG];
  lst_pkg::val_t               seg_high  [2][NTYPES][lst_pkg::NSEG];

  // The open client batch.
  lst_pkg::val_t [lst_pkg::NSEG-1:0] batch_acc;
  logic [lst_pkg::BCNT_W-1:0]        batch_n;
  logic                              batch_known;
  logic [lst_pkg::TYPE_W-1:0]        batch_kind;

  // Read answers still owed by the block, oldest first.
  readout_t pending_reads [$];

  dir_row_t dir_rows [NDIR];

  latency_stats_table_top #(
    .NUM_TYPES(NTYPES)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .side           (side),
    .record_valid   (record_valid),
    .req_kind       (req_kind),
    .batch_last     (batch_last),
    .req_net_time   (req_net_time),
    .reply_net_time (reply_net_time),
    .queue_time     (queue_time),
    .process_time   (process_time),
    .fs_time        (fs_time),
    .segment_sel    (segment_sel),
    .now_seconds    (now_seconds),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .entry_count    (entry_count),
    .seg_sum        (seg_sum),
    .seg_min        (seg_min),
    .seg_max        (seg_max),
    .reset_stamp    (reset_stamp)
  );

  // Period of 8: four high, four low.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Prints one line per mismatch, up to a cap, and counts every one of them.
  task automatic report(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------------

  // Clearing a table leaves minimums at all ones so that the first sample wins.
  function automatic void wipe_side(input logic sd, input logic [lst_pkg::STAMP_W-1:0] stamp);
    for (int t = 0; t < NTYPES; t++) begin
      tally[sd][t]    = '0;
      stamp_of[sd][t] = stamp;
      for (int k = 0; k < lst_pkg::NSEG; k++) begin
        seg_total[sd][t][k] = '0;
        seg_low[sd][t][k]   = lst_pkg::ALL_ONES;
        seg_high[sd][t][k]  = '0;
      end
    end
  endfunction

  function automatic void drop_batch();
    batch_acc   = '0;
    batch_n     = '0;
    batch_known = 1'b0;
    batch_kind  = '0;
  endfunction

  // Adds a count and five segment values to one entry; each value also moves min and max.
  function automatic void fold_entry(input logic sd, input logic [lst_pkg::TYPE_W-1:0] t,
                                     input lst_pkg::val_t cnt,
                                     input lst_pkg::val_t [lst_pkg::NSEG-1:0] v);
    tally[sd][t] += cnt;
    for (int k = 0; k < lst_pkg::NSEG; k++) begin
      seg_total[sd][t][k] += v[k];
      if (v[k] > seg_high[sd][t][k]) seg_high[sd][t][k] = v[k];
      if (v[k] < seg_low[sd][t][k]) seg_low[sd][t][k] = v[k];
    end
  endfunction

  // Applies one accepted item to the tables; a read returns the answer the block owes.
  function automatic void account_item(input stim_t s, output logic answers,
                                       output readout_t r);
    lst_pkg::val_t [lst_pkg::NSEG-1:0] v;
    lst_pkg::val_t rq;
    lst_pkg::val_t rp;
    lst_pkg::val_t q;
    lst_pkg::val_t p;
    lst_pkg::val_t f;
    rq = lst_pkg::val_t'(s.req_t);
    rp = lst_pkg::val_t'(s.rep_t);
    q  = lst_pkg::val_t'(s.q_t);
    p  = lst_pkg::val_t'(s.p_t);
    f  = lst_pkg::val_t'(s.f_t);
    answers = 1'b0;
    r = '0;
    v = '0;
    case (s.op)
      lst_pkg::OP_CLIENT: begin
        if (s.rec_ok) begin
          if (!batch_known) begin
            batch_known = 1'b1;
            batch_kind  = s.rtype;
          end
          // Network and total need both timestamps; all differences wrap.
          if (rq != '0 && rp != '0) begin
            batch_acc[lst_pkg::SEG_TOTAL] += rp - rq;
            batch_acc[lst_pkg::SEG_NET]   += rp - rq - q - p;
          end
          batch_acc[lst_pkg::SEG_FS]    += f;
          batch_acc[lst_pkg::SEG_QUEUE] += q;
          batch_acc[lst_pkg::SEG_OVH]   += p - f;
          batch_n++;
        end
        if (s.batch_end) begin
          if (batch_n != '0) begin
            fold_entry(1'b0, batch_kind, lst_pkg::val_t'(batch_n), batch_acc);
          end
          drop_batch();
        end
      end
      lst_pkg::OP_SERVER: begin
        v[lst_pkg::SEG_OVH]   = p - f;
        v[lst_pkg::SEG_FS]    = f;
        v[lst_pkg::SEG_QUEUE] = q;
        v[lst_pkg::SEG_NET]   = '0;
        v[lst_pkg::SEG_TOTAL] = q + p;
        fold_entry(1'b1, s.rtype, lst_pkg::val_t'(1), v);
      end
      lst_pkg::OP_RESET: begin
        wipe_side(s.side, s.now);
      end
      default: begin
        answers = 1'b1;
        r.count = tally[s.side][s.rtype];
        r.stamp = stamp_of[s.side][s.rtype];
        r.lo    = lst_pkg::ALL_ONES;
        if (s.sel < lst_pkg::NSEG) begin
          r.sum = seg_total[s.side][s.rtype][s.sel];
          r.lo  = seg_low[s.side][s.rtype][s.sel];
          r.hi  = seg_high[s.side][s.rtype][s.sel];
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  function automatic stim_t client_rec(input logic ok, input int t, input logic fin,
                                       input logic [lst_pkg::TIME_W-1:0] rq,
                                       input logic [lst_pkg::TIME_W-1:0] rp,
                                       input logic [lst_pkg::TIME_W-1:0] q,
                                       input logic [lst_pkg::TIME_W-1:0] p,
                                       input logic [lst_pkg::TIME_W-1:0] f);
    stim_t s;
    s = '0;
    s.op        = lst_pkg::OP_CLIENT;
    s.rec_ok    = ok;
    s.rtype     = t[lst_pkg::TYPE_W-1:0];
    s.batch_end = fin;
    s.req_t     = rq;
    s.rep_t     = rp;
    s.q_t       = q;
    s.p_t       = p;
    s.f_t       = f;
    return s;
  endfunction

  function automatic stim_t server_rec(input int t, input logic [lst_pkg::TIME_W-1:0] q,
                                       input logic [lst_pkg::TIME_W-1:0] p,
                                       input logic [lst_pkg::TIME_W-1:0] f);
    stim_t s;
    s = '0;
    s.op    = lst_pkg::OP_SERVER;
    s.rtype = t[lst_pkg::TYPE_W-1:0];
    s.q_t   = q;
    s.p_t   = p;
    s.f_t   = f;
    return s;
  endfunction

  function automatic stim_t reset_tab(input logic sd, input logic [lst_pkg::STAMP_W-1:0] stamp);
    stim_t s;
    s = '0;
    s.op   = lst_pkg::OP_RESET;
    s.side = sd;
    s.now  = stamp;
    return s;
  endfunction

  function automatic stim_t read_seg(input logic sd, input int t, input int sel);
    stim_t s;
    s = '0;
    s.op    = lst_pkg::OP_READ;
    s.side  = sd;
    s.rtype = t[lst_pkg::TYPE_W-1:0];
    s.sel   = sel[lst_pkg::SEL_W-1:0];
    return s;
  endfunction

  // What a read of a freshly cleared entry answers, whatever the segment.
  function automatic readout_t cleared(input logic [lst_pkg::STAMP_W-1:0] stamp);
    readout_t r;
    r = '0;
    r.lo    = lst_pkg::ALL_ONES;
    r.stamp = stamp;
    return r;
  endfunction

  function automatic dir_row_t pinned_row(input stim_t s, input readout_t want);
    dir_row_t d;
    d.stim   = s;
    d.pinned = 1'b1;
    d.want   = want;
    return d;
  endfunction

  function automatic dir_row_t modeled_row(input stim_t s);
    dir_row_t d;
    d.stim   = s;
    d.pinned = 1'b0;
    d.want   = '0;
    return d;
  endfunction

  // Random times lean toward realistic small values but hit zero, the top and full width.
  function automatic logic [lst_pkg::TIME_W-1:0] pick_time();
    logic [lst_pkg::TIME_W-1:0] x;
    x = lst_pkg::TIME_W'({$urandom, $urandom});
    case ($urandom_range(0, 7))
      0:       x = '0;
      1:       x = '1;
      2, 3:    ;
      default: x = lst_pkg::TIME_W'($urandom_range(1, 5000));
    endcase
    return x;
  endfunction

  // Most traffic piles onto a few types so that entries build up history.
  function automatic int pick_type();
    case ($urandom_range(0, 19))
      0, 1, 2: return $urandom_range(NTYPES - 4, NTYPES - 1);
      3, 4, 5: return $urandom_range(0, NTYPES - 1);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // Every field random over its full width; callers then shape what matters.
  function automatic stim_t noise_item();
    stim_t s;
    s.op        = lst_pkg::op_t'($urandom_range(0, 3));
    s.side      = 1'($urandom_range(0, 1));
    s.rec_ok    = 1'($urandom_range(0, 1));
    s.rtype     = lst_pkg::TYPE_W'($urandom_range(0, NTYPES - 1));
    s.batch_end = 1'($urandom_range(0, 1));
    s.req_t     = lst_pkg::TIME_W'({$urandom, $urandom});
    s.rep_t     = lst_pkg::TIME_W'({$urandom, $urandom});
    s.q_t       = lst_pkg::TIME_W'({$urandom, $urandom});
    s.p_t       = lst_pkg::TIME_W'({$urandom, $urandom});
    s.f_t       = lst_pkg::TIME_W'({$urandom, $urandom});
    s.sel       = lst_pkg::SEL_W'($urandom_range(0, SEG_TOP));
    s.now       = lst_pkg::STAMP_W'({$urandom, $urandom});
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  // Called at a falling edge and returns at one. Valid may stay high from the previous item;
  // it only drops while the sender idles. Once raised it holds until the rising edge that
  // accepts the item, and only then does the model see the item.
  task automatic send_item(input stim_t s, input logic pinned, input readout_t want);
    logic     answers;
    readout_t r;
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    op             = s.op;
    side           = s.side;
    record_valid   = s.rec_ok;
    req_kind       = s.rtype;
    batch_last     = s.batch_end;
    req_net_time   = s.req_t;
    reply_net_time = s.rep_t;
    queue_time     = s.q_t;
    process_time   = s.p_t;
    fs_time        = s.f_t;
    segment_sel    = s.sel;
    now_seconds    = s.now;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    account_item(s, answers, r);
    if (answers) pending_reads.push_back(pinned ? want : r);
    @(negedge clk);
  endtask

  // Holds the sender back until the block has returned every answer it owes.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (pending_reads.size() != 0) @(negedge clk);
  endtask

  // One random phase. Most items are well-formed client batches, server records and reads
  // spread over a few hot types; a few table resets and fully random items are mixed in.
  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    int    done;
    int    choice;
    int    n;
    int    t;
    stim_t s;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < PHASE_ITEMS) begin
      choice = $urandom_range(0, 99);
      if (choice < 40) begin
        n = $urandom_range(1, 5);
        t = pick_type();
        for (int i = 0; i < n; i++) begin
          s = noise_item();
          s.op        = lst_pkg::OP_CLIENT;
          s.rec_ok    = ($urandom_range(0, 7) != 0);
          s.batch_end = (i == n - 1);
          if (i == 0) s.rtype = t[lst_pkg::TYPE_W-1:0];
          s.req_t = pick_time();
          // Usually the reply follows the request; sometimes the two are unrelated.
          if ($urandom_range(0, 1) != 0) begin
            s.rep_t = s.req_t + lst_pkg::TIME_W'($urandom_range(0, 100000));
          end else begin
            s.rep_t = pick_time();
          end
          s.q_t = pick_time();
          s.p_t = pick_time();
          s.f_t = pick_time();
          send_item(s, 1'b0, '0);
          done++;
        end
      end else begin
        s = noise_item();
        if (choice < 60) begin
          s.op    = lst_pkg::OP_SERVER;
          s.rtype = lst_pkg::TYPE_W'(pick_type());
          s.q_t   = pick_time();
          s.p_t   = pick_time();
          s.f_t   = pick_time();
        end else if (choice < 95) begin
          s.op    = lst_pkg::OP_READ;
          s.rtype = lst_pkg::TYPE_W'(pick_type());
          if ($urandom_range(0, 9) != 0) begin
            s.sel = lst_pkg::SEL_W'($urandom_range(0, lst_pkg::NSEG - 1));
          end
        end else if (choice < 97) begin
          s.op = lst_pkg::OP_RESET;
        end
        send_item(s, 1'b0, '0);
        done++;
      end
    end
    wait_for_results();
  endtask

  // The receiver decides at each falling edge whether it takes an answer at the next edge.
  always @(negedge clk) begin
    out_ready = ($urandom_range(1, 100) > recv_stall_pct);
  end

  // Every accepted answer is matched against the oldest one owed.
  always @(posedge clk) begin : answer_check
    readout_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        report("read answer arrived with none outstanding");
      end else begin
        want = pending_reads.pop_front();
        if (entry_count !== want.count)
          report($sformatf("entry_count %h, expected %h", entry_count, want.count));
        if (seg_sum !== want.sum)
          report($sformatf("seg_sum %h, expected %h", seg_sum, want.sum));
        if (seg_min !== want.lo)
          report($sformatf("seg_min %h, expected %h", seg_min, want.lo));
        if (seg_max !== want.hi)
          report($sformatf("seg_max %h, expected %h", seg_max, want.hi));
        if (reset_stamp !== want.stamp)
          report($sformatf("reset_stamp %h, expected %h", reset_stamp, want.stamp));
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
               pending_reads.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    in_valid       = 1'b0;
    out_ready      = 1'b0;
    op             = lst_pkg::OP_CLIENT;
    side           = 1'b0;
    record_valid   = 1'b0;
    req_kind       = '0;
    batch_last     = 1'b0;
    req_net_time   = '0;
    reply_net_time = '0;
    queue_time     = '0;
    process_time   = '0;
    fs_time        = '0;
    segment_sel    = '0;
    now_seconds    = '0;
    wipe_side(1'b0, '0);
    wipe_side(1'b1, '0);
    drop_batch();

    // Directed rows. Answers after a reset or a table clear are typed in; the rest come
    // from the model.
    // Fresh tables on both sides, including a segment select past the last segment.
    dir_rows[0]  = pinned_row(read_seg(1'b0, 0, lst_pkg::SEG_OVH), cleared('0));
    dir_rows[1]  = pinned_row(read_seg(1'b1, NTYPES - 1, lst_pkg::SEG_TOTAL), cleared('0));
    dir_rows[2]  = pinned_row(read_seg(1'b0, 17, SEG_TOP), cleared('0));
    // Server records at the top of every time field, then one whose overhead goes negative.
    dir_rows[3]  = modeled_row(server_rec(NTYPES - 1, TIME_MAX, TIME_MAX, TIME_MAX));
    dir_rows[4]  = modeled_row(server_rec(NTYPES - 1, '0, '0, TIME_MAX));
    dir_rows[5]  = modeled_row(read_seg(1'b1, NTYPES - 1, lst_pkg::SEG_OVH));
    dir_rows[6]  = modeled_row(read_seg(1'b1, NTYPES - 1, lst_pkg::SEG_TOTAL));
    // A client batch: an invalid record in the middle, a later type that must not take
    // over, one record without a request stamp and one without a reply stamp.
    dir_rows[7]  = modeled_row(client_rec(1'b1, 5, 1'b0, 48'd100, 48'd1000, 48'd30, 48'd400,
                                          48'd50));
    dir_rows[8]  = modeled_row(client_rec(1'b0, 40, 1'b0, TIME_MAX, TIME_MAX, TIME_MAX,
                                          TIME_MAX, TIME_MAX));
    dir_rows[9]  = modeled_row(client_rec(1'b1, 9, 1'b0, '0, 48'd2000, 48'd10, 48'd20,
                                          48'd5));
    dir_rows[10] = modeled_row(client_rec(1'b1, 5, 1'b1, 48'd700, '0, 48'd1, 48'd2, 48'd3));
    dir_rows[11] = modeled_row(read_seg(1'b0, 5, lst_pkg::SEG_NET));
    dir_rows[12] = modeled_row(read_seg(1'b0, 5, lst_pkg::SEG_FS));
    dir_rows[13] = modeled_row(read_seg(1'b0, 9, lst_pkg::SEG_FS));
    // A reply stamped before its request makes total and network time wrap.
    dir_rows[14] = modeled_row(client_rec(1'b1, 0, 1'b1, TIME_MAX, 48'd1, '0, '0, '0));
    // Closing an empty batch must leave the tables alone.
    dir_rows[15] = modeled_row(client_rec(1'b0, 0, 1'b1, '0, '0, '0, '0, '0));
    dir_rows[16] = modeled_row(read_seg(1'b0, 0, lst_pkg::SEG_TOTAL));
    // Clearing the client table with the largest stamp leaves the server table intact.
    dir_rows[17] = modeled_row(reset_tab(1'b0, STAMP_MAX));
    dir_rows[18] = pinned_row(read_seg(1'b0, 5, lst_pkg::SEG_FS), cleared(STAMP_MAX));
    dir_rows[19] = modeled_row(read_seg(1'b1, NTYPES - 1, lst_pkg::SEG_QUEUE));
    // A batch left open across a table clear still lands when it closes.
    dir_rows[20] = modeled_row(client_rec(1'b1, 7, 1'b0, 48'd1, 48'd2, 48'd3, 48'd4, 48'd5));
    dir_rows[21] = modeled_row(reset_tab(1'b0, 40'd1));
    dir_rows[22] = modeled_row(client_rec(1'b1, 7, 1'b1, 48'd10, 48'd20, 48'd1, 48'd1,
                                          48'd1));
    dir_rows[23] = modeled_row(read_seg(1'b0, 7, lst_pkg::SEG_QUEUE));
    dir_rows[24] = modeled_row(reset_tab(1'b1, '0));
    dir_rows[25] = pinned_row(read_seg(1'b1, NTYPES - 1, SEG_BEYOND), cleared('0));

    // Synchronous reset; the block then sweeps both tables before it takes
    // the first item, which the sender simply waits out through the handshake.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NDIR; i++) begin
      send_item(dir_rows[i].stim, dir_rows[i].pinned, dir_rows[i].want);
    end
    // The sender stops here until every directed answer is back.
    wait_for_results();

    // Random phases: no idling, a slow sender, a slow receiver, then both at once.
    run_random_phase(0, 0);
    run_random_phase(84, 0);
    run_random_phase(0, 84);
    run_random_phase(30, 30);

    // Nothing is owed any more; give a trailing table clear time to finish so that any
    // stray answer still shows up as a failure.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
